// ===== design/wmn_pkg.sv =====
// Shared types and constants for the weighted multipath next-hop selector.
// No dependencies; every other design file imports this package.
package wmn_pkg;

  localparam int WEIGHT_FIELDS = 8;
  localparam int WEIGHT_W      = 8;
  localparam int MAX_HOPS_DEF  = 8;
  localparam int HOP_W         = 3;
  localparam int CNT_W         = 4;
  localparam int CREDIT_W      = 9;
  localparam int TOTAL_W       = 12;
  localparam int TICK_W        = 32;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 1;
  localparam int DIV_CNT_W     = 5;
  localparam int REM_W         = 14;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOP_COUNT = 1'b1;

  localparam logic [1:0] ACT_SELECT = 2'd0;
  localparam logic [1:0] ACT_KILL   = 2'd1;
  localparam logic [1:0] ACT_REVIVE = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_WEIGHT = 2'd1;
  localparam logic [1:0] STATUS_NO_PICK   = 2'd2;

  typedef enum logic [1:0] {
    OP_SELECT,
    OP_KILL,
    OP_REVIVE,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REFILL,
    ST_PREP,
    ST_DIV,
    ST_WALK,
    ST_EDIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [TICK_W-1:0] tick;
    logic [HOP_W-1:0]  hop_index;
  } in_item_t;

  typedef struct packed {
    logic [HOP_W-1:0] selected_hop;
    logic [1:0]       status;
    logic             route_dead;
  } out_item_t;

  typedef struct packed {
    op_e               op;
    logic [TICK_W-1:0] tick;
    logic [HOP_W-1:0]  hop;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

endpackage

// ===== design/wmn_front.sv =====
// Front stage: request register and decode of the action into a queued job.
// Depends on wmn_pkg.
module wmn_front import wmn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  input  logic [CNT_W-1:0] hops_i,
  input  logic             q_full_i,
  output push_t            push_o
);

  logic  front_valid_q, front_valid_d;
  job_t  front_q, front_d;
  logic  accept;
  logic  push;
  logic  in_use;

  assign in_stall_o = front_valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = front_valid_q && !q_full_i;
  assign in_use     = CNT_W'(in_item_i.hop_index) < hops_i;

  always_comb begin
    front_d       = front_q;
    front_valid_d = front_valid_q;
    if (push) begin
      front_valid_d = 1'b0;
    end
    if (accept) begin
      front_valid_d = 1'b1;
      front_d.tick  = in_item_i.tick;
      front_d.hop   = in_item_i.hop_index;
      // drop edits of hops that are not in use
      unique case (in_item_i.action)
        ACT_SELECT: front_d.op = OP_SELECT;
        ACT_KILL:   front_d.op = in_use ? OP_KILL : OP_NOP;
        ACT_REVIVE: front_d.op = in_use ? OP_REVIVE : OP_NOP;
        default:    front_d.op = OP_NOP;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else begin
      front_valid_q <= front_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
  end

  assign push_o.valid = push;
  assign push_o.job   = front_q;

endmodule

// ===== design/wmn_queue.sv =====
// Short job queue between the front stage and the execution engine.
// Depends on wmn_pkg.
module wmn_queue import wmn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output job_t  job_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  job_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_QW-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o  = count_q == CNT_QW'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

endmodule

// ===== design/wmn_back.sv =====
// Execution engine: credit refill, serial modulo, hop walk, edits, result register.
// Depends on wmn_pkg.
module wmn_back import wmn_pkg::*; #(
  parameter int HOP_LIMIT = MAX_HOPS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] weights_i,
  input  logic [CNT_W-1:0] hops_i,
  input  logic             q_valid_i,
  input  job_t             q_job_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o
);

  localparam logic [TOTAL_W-1:0] MaxTotal = TOTAL_W'(HOP_LIMIT * (1 << WEIGHT_W));

  state_e                  state_q, state_d;
  logic [CREDIT_W-1:0]     credit_q [HOP_LIMIT];
  logic [HOP_LIMIT-1:0]    dead_q, dead_d;
  logic [TOTAL_W-1:0]      total_q, total_d;
  logic [TOTAL_W-1:0]      sum_q, sum_d;
  logic [HOP_W-1:0]        idx_q, idx_d;
  logic [DIV_CNT_W-1:0]    bit_q, bit_d;
  logic [TICK_W-1:0]       tick_q, tick_d;
  logic [TOTAL_W-1:0]      rem_q, rem_d;
  logic signed [REM_W-1:0] wrem_q, wrem_d;
  op_e                     op_q, op_d;
  logic [HOP_W-1:0]        res_sel_q, res_sel_d;
  logic [1:0]              res_status_q, res_status_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q, out_d;

  logic                    cr_we;
  logic [CREDIT_W-1:0]     cr_wdata;
  logic [CREDIT_W-1:0]     cred;
  logic                    cur_dead;
  logic signed [REM_W-1:0] cred_ext, nrem;
  logic [CREDIT_W-1:0]     weight;
  logic [TOTAL_W:0]        trial;
  logic [TOTAL_W-1:0]      rem_next;
  logic                    last_hop;
  logic                    eligible;
  logic                    any_alive;
  logic                    out_free;
  logic                    dead_with_credit;

  // read port at the walk index
  always_comb begin
    cred     = '0;
    cur_dead = 1'b0;
    for (int i = 0; i < HOP_LIMIT; i++) begin
      if (idx_q == HOP_W'(i)) begin
        cred     = credit_q[i];
        cur_dead = dead_q[i];
      end
    end
  end

  always_comb begin
    any_alive        = 1'b0;
    dead_with_credit = 1'b0;
    for (int i = 0; i < HOP_LIMIT; i++) begin
      if (CNT_W'(i) < hops_i && !dead_q[i]) begin
        any_alive = 1'b1;
      end
      if (dead_q[i] && credit_q[i] != '0) begin
        dead_with_credit = 1'b1;
      end
    end
  end

  assign weight   = CREDIT_W'(weights_i[WEIGHT_W*idx_q +: WEIGHT_W]) + 1'b1;
  assign cred_ext = REM_W'(cred);
  assign nrem     = wrem_q - cred_ext;
  assign eligible = !cur_dead && cred != '0;
  assign last_hop = CNT_W'(idx_q) == hops_i - CNT_W'(1);
  assign trial    = {rem_q, tick_q[TICK_W-1]};
  assign rem_next = (trial >= {1'b0, total_q}) ? TOTAL_W'(trial - {1'b0, total_q})
                                               : TOTAL_W'(trial);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    dead_d       = dead_q;
    total_d      = total_q;
    sum_d        = sum_q;
    idx_d        = idx_q;
    bit_d        = bit_q;
    tick_d       = tick_q;
    rem_d        = rem_q;
    wrem_d       = wrem_q;
    op_d         = op_q;
    res_sel_d    = res_sel_q;
    res_status_d = res_status_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    cr_we        = 1'b0;
    cr_wdata     = '0;
    q_pop_o      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o      = 1'b1;
          op_d         = q_job_i.op;
          tick_d       = q_job_i.tick;
          res_sel_d    = '0;
          res_status_d = STATUS_OK;
          sum_d        = '0;
          unique case (q_job_i.op)
            OP_SELECT: begin
              idx_d   = '0;
              state_d = (total_q == '0) ? ST_REFILL : ST_PREP;
            end
            OP_KILL, OP_REVIVE: begin
              idx_d   = q_job_i.hop;
              state_d = ST_EDIT;
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_REFILL: begin
        // load alive hops with their weight, one hop a cycle
        if (!cur_dead) begin
          cr_we    = 1'b1;
          cr_wdata = weight;
          sum_d    = sum_q + TOTAL_W'(weight);
        end
        if (last_hop) begin
          total_d = sum_d;
          state_d = ST_PREP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_PREP: begin
        if (total_q == '0) begin
          res_status_d = STATUS_NO_WEIGHT;
          state_d      = ST_OUT;
        end else begin
          rem_d   = '0;
          bit_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // restoring modulo, one tick bit a cycle
        rem_d  = rem_next;
        tick_d = tick_q << 1;
        bit_d  = bit_q + 1'b1;
        if (bit_q == DIV_CNT_W'(TICK_W - 1)) begin
          wrem_d  = REM_W'(rem_next);
          idx_d   = '0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (eligible && nrem <= 0) begin
          cr_we     = 1'b1;
          cr_wdata  = cred - 1'b1;
          total_d   = total_q - 1'b1;
          res_sel_d = idx_q;
          state_d   = ST_OUT;
        end else begin
          if (eligible) begin
            wrem_d = nrem;
          end
          if (last_hop) begin
            res_status_d = STATUS_NO_PICK;
            state_d      = ST_OUT;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_EDIT: begin
        for (int i = 0; i < HOP_LIMIT; i++) begin
          if (idx_q == HOP_W'(i)) begin
            if (op_q == OP_KILL && !cur_dead) begin
              dead_d[i] = 1'b1;
              cr_we     = 1'b1;
              total_d   = (total_q >= TOTAL_W'(cred)) ? total_q - TOTAL_W'(cred) : '0;
            end else if (op_q == OP_REVIVE && cur_dead) begin
              dead_d[i] = 1'b0;
              cr_we     = 1'b1;
            end
          end
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold until the result register frees up
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.selected_hop = res_sel_q;
          out_d.status       = res_status_q;
          out_d.route_dead   = !any_alive;
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dead_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < HOP_LIMIT; i++) begin
        credit_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      dead_q      <= dead_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < HOP_LIMIT; i++) begin
        if (cr_we && idx_q == HOP_W'(i)) begin
          credit_q[i] <= cr_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q        <= sum_d;
    idx_q        <= idx_d;
    bit_q        <= bit_d;
    tick_q       <= tick_d;
    rem_q        <= rem_d;
    wrem_q       <= wrem_d;
    op_q         <= op_d;
    res_sel_q    <= res_sel_d;
    res_status_q <= res_status_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= MaxTotal)
    else $error("credit total above the sum of all weights");

  a_rem_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> (total_q != '0 && rem_q < total_q))
    else $error("modulo remainder not below the total");

  a_dead_no_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dead_with_credit)
    else $error("dead hop still holds credit");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result loaded outside the result state");

endmodule

// ===== design/weighted_multipath_nexthop_select.sv =====
// Weighted multipath next-hop selector: one route, up to eight hops.
// Channels: request in (in_valid_i / in_stall_o / in_item_i), result out
// (out_valid_o / out_stall_i / out_item_o), each moving on valid and not stall.
// Every request gives exactly one result, in order.
// Config: write cfg_we_i with cfg_index_i 0 for the weight table, 1 for the hop
// count; write only while no request is in flight.
// Operation: a select's time from request to result is set by the bit-serial
// 32-bit modulo of the tick by the credit total plus the walk over the hops in
// use and, when the total is empty, the refill over them. One request executes
// at a time; the front register and a two-entry queue take up to three more
// requests meanwhile.
// Reset: every hop alive with zero credit, total zero so the first select
// refills; weights zero (weight 1 each), hop count 1.
// A stalled result holds in the output register; the engine waits in its
// result state and the queue fills until in_stall_o rises.
// Depends on wmn_pkg, wmn_front, wmn_queue, wmn_back.
module weighted_multipath_nexthop_select import wmn_pkg::*; #(
  parameter int MAX_HOPS = MAX_HOPS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int HopLimit = (MAX_HOPS < WEIGHT_FIELDS) ? MAX_HOPS : WEIGHT_FIELDS;

  logic [CFG_W-1:0] weights_q;
  logic [CNT_W-1:0] hop_count_q;
  logic [CNT_W-1:0] hops;
  push_t            push;
  logic             q_full, q_valid, q_pop;
  job_t             q_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q   <= '0;
      hop_count_q <= CNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WEIGHTS:   weights_q   <= cfg_data_i;
        CFG_HOP_COUNT: hop_count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the hop count to one through the hop limit
  always_comb begin
    if (hop_count_q == '0) begin
      hops = CNT_W'(1);
    end else if (hop_count_q > CNT_W'(HopLimit)) begin
      hops = CNT_W'(HopLimit);
    end else begin
      hops = hop_count_q;
    end
  end

  wmn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .hops_i     (hops),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  wmn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  wmn_back #(
    .HOP_LIMIT (HopLimit)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .weights_i   (weights_q),
    .hops_i      (hops),
    .q_valid_i   (q_valid),
    .q_job_i     (q_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
